// ----- src/mswdt_pkg.sv -----
package mswdt_pkg;

   // Number of watchdog slots and the width of a slot index.
   localparam int SLOTS  = 32;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam int OP_W     = 3;
   localparam int FSLOT_W  = 5;
   localparam int COUNT_W  = 16;
   localparam int OWNER_W  = 22;
   localparam int STATUS_W = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_REGISTER     = 3'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER   = 3'd1;
   localparam logic [OP_W-1:0] OP_FEED         = 3'd2;
   localparam logic [OP_W-1:0] OP_CHECK        = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE_OWNER = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NO_FREE   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_BAD_SLOT  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_EXPIRED   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NO_EXPIRY = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [FSLOT_W-1:0] slot;
      logic [COUNT_W-1:0] tick_value;
      logic [OWNER_W-1:0] owner_id;
      logic               wants_reboot;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FSLOT_W-1:0]  slot_index;
      logic [OWNER_W-1:0]  expired_owner;
   } rsp_type;

endpackage

// ----- src/multi_slot_watchdog_table_core.sv -----
// A transaction visits N slots in the execute state before its result is held: N is one for
// unregister, feed, unknown ops and remove-owner of owner 0; register, check and remove-owner
// visit one slot per cycle through a single slot port, up to SLOTS.
// One transaction is in work at a time; the next is accepted once the previous result has
// moved to the output register, later while a stalled result still occupies that register.
// Reset clears all valid bits, the scan cursor and the output valid; counts and owners matter
// only for slots whose valid bit is set, and register writes both as it sets that bit.
module multi_slot_watchdog_table_core
   import mswdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0]  cursor_ff, cursor_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [COUNT_W-1:0] count_ff [SLOTS];
   logic [OWNER_W-1:0] owner_ff [SLOTS];
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               cnt_we;
   logic [SLOT_W-1:0]  cnt_wa;
   logic [COUNT_W-1:0] cnt_wd;
   logic               own_we;
   logic [OWNER_W-1:0] own_wd;
   logic [COUNT_W-1:0] rd_count;
   logic [OWNER_W-1:0] rd_owner;
   logic [SLOT_W-1:0]  slot_idx;
   logic               slot_ok;
   logic               last;
   logic               done;
   logic               out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rd_count = count_ff[idx_ff];
   assign rd_owner = owner_ff[idx_ff];
   assign slot_idx = SLOT_W'(req_ff.slot);
   assign slot_ok  = (int'(req_ff.slot) < SLOTS);
   assign last     = (idx_ff == SLOT_W'(SLOTS - 1));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cursor_in    = cursor_ff;
      valid_in     = valid_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cnt_we       = 1'b0;
      cnt_wa       = idx_ff;
      cnt_wd       = '0;
      own_we       = 1'b0;
      own_wd       = '0;
      done         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = (req_data.op == OP_CHECK) ? cursor_ff : '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in.status        = STS_OK;
            res_in.slot_index    = '0;
            res_in.expired_owner = '0;
            unique case (req_ff.op)
               OP_REGISTER: begin
                  if (!valid_ff[idx_ff]) begin
                     valid_in[idx_ff]  = 1'b1;
                     cnt_we            = 1'b1;
                     own_we            = 1'b1;
                     own_wd            = req_ff.wants_reboot ? '0 : req_ff.owner_id;
                     res_in.slot_index = FSLOT_W'(idx_ff);
                     done              = 1'b1;
                  end else if (last) begin
                     res_in.status = STS_NO_FREE;
                     done          = 1'b1;
                  end
               end
               OP_UNREGISTER: begin
                  if (slot_ok) begin
                     valid_in[slot_idx] = 1'b0;
                  end else begin
                     res_in.status = STS_BAD_SLOT;
                  end
                  done = 1'b1;
               end
               OP_FEED: begin
                  if (slot_ok) begin
                     cnt_we = 1'b1;
                     cnt_wa = slot_idx;
                     cnt_wd = req_ff.tick_value;
                  end else begin
                     res_in.status = STS_BAD_SLOT;
                  end
                  done = 1'b1;
               end
               OP_CHECK: begin
                  // A slot holding one stops the scan and keeps the cursor on it.
                  if (valid_ff[idx_ff] && rd_count == COUNT_W'(1)) begin
                     res_in.status        = STS_EXPIRED;
                     res_in.slot_index    = FSLOT_W'(idx_ff);
                     res_in.expired_owner = rd_owner;
                     cursor_in            = idx_ff;
                     done                 = 1'b1;
                  end else begin
                     if (valid_ff[idx_ff] && rd_count != '0) begin
                        cnt_we = 1'b1;
                        cnt_wd = rd_count - COUNT_W'(1);
                     end
                     if (last) begin
                        res_in.status = STS_NO_EXPIRY;
                        cursor_in     = '0;
                        done          = 1'b1;
                     end
                  end
               end
               OP_REMOVE_OWNER: begin
                  if (req_ff.owner_id == '0) begin
                     done = 1'b1;
                  end else begin
                     if (rd_owner == req_ff.owner_id) begin
                        valid_in[idx_ff] = 1'b0;
                     end
                     done = last;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               state_in = S_HOLD;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (cnt_we) begin
         count_ff[cnt_wa] <= cnt_wd;
      end
      if (own_we) begin
         owner_ff[idx_ff] <= own_wd;
      end
   end

   // An accepted transaction always starts execution in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_EXEC)
      else $error("accepted transaction did not start execution");

   // A finished result moves to the output as soon as the output is free.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD && out_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished result was not delivered to the output");

   // An expiry leaves the scan cursor on the slot that was reported.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && done && res_in.status == STS_EXPIRED
      |=> cursor_ff == $past(idx_ff))
      else $error("scan cursor not kept on the expired slot");

endmodule

// ----- tb/testbench.sv -----
module testbench;
   import mswdt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1900;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_CYCLES = 400;
   localparam logic [OP_W-1:0]    OP_TOP    = OP_W'((1 << OP_W) - 1);
   localparam logic [OWNER_W-1:0] OWNER_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   multi_slot_watchdog_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Watchdog table as the testbench sees it.
   logic               tbl_valid [SLOTS];
   logic [COUNT_W-1:0] tbl_count [SLOTS];
   logic [OWNER_W-1:0] tbl_owner [SLOTS];
   logic [SLOT_W-1:0]  scan_pos;

   req_type pending_reqs [$];
   rsp_type predicted_results [$];
   logic [OWNER_W-1:0] owner_pool [6];

   int unsigned accepted_reqs = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned mode_left = 0;
   int unsigned hold_left = 0;
   int unsigned stall_mode = 0;
   logic        hold_done = 1'b0;

   function automatic rsp_type apply_watchdog_op(req_type req);
      rsp_type res;
      logic    found;
      int      hit;
      res = '0;
      res.status = STS_OK;
      case (req.op)
         OP_REGISTER: begin
            res.status = STS_NO_FREE;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && !tbl_valid[i]) begin
                  found = 1'b1;
                  tbl_valid[i] = 1'b1;
                  tbl_count[i] = '0;
                  tbl_owner[i] = req.wants_reboot ? '0 : req.owner_id;
                  res.status = STS_OK;
                  res.slot_index = FSLOT_W'(i);
               end
            end
         end
         OP_UNREGISTER: begin
            if (int'(req.slot) < SLOTS) tbl_valid[req.slot] = 1'b0;
            else res.status = STS_BAD_SLOT;
         end
         OP_FEED: begin
            if (int'(req.slot) < SLOTS) tbl_count[req.slot] = req.tick_value;
            else res.status = STS_BAD_SLOT;
         end
         OP_CHECK: begin
            // The scan resumes at the kept cursor and halts on the first slot
            // about to expire, without decrementing it.
            res.status = STS_NO_EXPIRY;
            found = 1'b0;
            hit = 0;
            for (int i = int'(scan_pos); i < SLOTS; i++) begin
               if (!found && tbl_valid[i] && tbl_count[i] != 0) begin
                  if (tbl_count[i] == 1) begin
                     found = 1'b1;
                     hit = i;
                  end else begin
                     tbl_count[i] = tbl_count[i] - COUNT_W'(1);
                  end
               end
            end
            if (found) begin
               res.status = STS_EXPIRED;
               res.slot_index = FSLOT_W'(hit);
               res.expired_owner = tbl_owner[hit];
               scan_pos = SLOT_W'(hit);
            end else begin
               scan_pos = '0;
            end
         end
         OP_REMOVE_OWNER: begin
            if (req.owner_id != 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (tbl_owner[i] == req.owner_id) tbl_valid[i] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [FSLOT_W-1:0] slot,
                            input logic [COUNT_W-1:0] tick, input logic [OWNER_W-1:0] owner,
                            input logic reboot);
      req_type r;
      r.op = op;
      r.slot = slot;
      r.tick_value = tick;
      r.owner_id = owner;
      r.wants_reboot = reboot;
      pending_reqs.push_back(r);
   endtask

   // Slots and owners are drawn mostly from small sets so that operations hit
   // slots that are actually registered.
   task automatic queue_random(input logic [OP_W-1:0] op);
      logic [FSLOT_W-1:0] slot;
      logic [COUNT_W-1:0] tick;
      logic [OWNER_W-1:0] owner;
      slot = ($urandom_range(0, 4) == 0) ? FSLOT_W'($urandom) : FSLOT_W'($urandom_range(0, 11));
      case ($urandom_range(0, 9))
         0, 1:    tick = '0;
         2, 3:    tick = COUNT_W'($urandom);
         default: tick = COUNT_W'($urandom_range(1, 4));
      endcase
      owner = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom) : owner_pool[$urandom_range(0, 5)];
      queue_req(op, slot, tick, owner, $urandom_range(0, 6) == 0);
   endtask

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
         error_count++;
      end
   endtask

   // Driver: offers queued transactions in bursts, usually separated by idle gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(10, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 4) == 0);
            default: rsp_stall <= ($urandom_range(0, 2) != 0);
         endcase
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted result.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $error("result transaction with no prediction pending: %0h", rsp_data);
               error_count++;
            end else begin
               exp_rsp = predicted_results.pop_front();
               check_field("status", 32'(exp_rsp.status), 32'(rsp_data.status));
               check_field("slot_index", 32'(exp_rsp.slot_index), 32'(rsp_data.slot_index));
               check_field("expired_owner", 32'(exp_rsp.expired_owner),
                           32'(rsp_data.expired_owner));
            end
         end
         if (req_valid && !req_stall) begin
            predicted_results.push_back(apply_watchdog_op(req_data));
            accepted_reqs++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned roll;
      int unsigned fill;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_count[i] = '0;
         tbl_owner[i] = '0;
      end
      scan_pos = '0;

      // Directed part: owner extremes, reboot owner, expiry and repeat,
      // paused slots, cursor resume, remove-owner cases, unknown codes.
      queue_req(OP_REGISTER, 0, 0, OWNER_MAX, 1'b1);
      queue_req(OP_REGISTER, 0, 0, OWNER_MAX, 1'b0);
      queue_req(OP_REGISTER, 0, 0, 1, 1'b0);
      queue_req(OP_FEED, 0, 1, 0, 1'b0);
      queue_req(OP_FEED, 1, COUNT_MAX, 0, 1'b0);
      queue_req(OP_FEED, FSLOT_W'(SLOTS - 1), 2, 0, 1'b0);
      queue_req(OP_CHECK, 0, 0, 0, 1'b0);
      queue_req(OP_CHECK, 0, 0, 0, 1'b0);
      queue_req(OP_FEED, 0, 0, 0, 1'b0);
      queue_req(OP_CHECK, 0, 0, 0, 1'b0);
      queue_req(OP_FEED, 2, 2, 0, 1'b0);
      queue_req(OP_CHECK, 0, 0, 0, 1'b0);
      queue_req(OP_CHECK, 0, 0, 0, 1'b0);
      queue_req(OP_REMOVE_OWNER, 0, 0, 0, 1'b0);
      queue_req(OP_REMOVE_OWNER, 0, 0, 1, 1'b0);
      queue_req(OP_CHECK, 0, 0, 0, 1'b0);
      queue_req(OP_UNREGISTER, FSLOT_W'(SLOTS - 1), 0, 0, 1'b0);
      queue_req(OP_UNREGISTER, 1, 0, 0, 1'b0);
      queue_req(OP_REGISTER, 0, 0, 22'h2AAAAA, 1'b0);
      queue_req(OP_REMOVE_OWNER, 0, 0, OWNER_MAX, 1'b0);
      for (int op = int'(OP_REMOVE_OWNER) + 1; op <= int'(OP_TOP); op++)
         queue_req(OP_W'(op), '1, COUNT_MAX, OWNER_MAX, 1'b1);
      queue_req(OP_UNREGISTER, 0, 0, 0, 1'b0);

      owner_pool[0] = '0;
      owner_pool[1] = OWNER_MAX;
      for (int i = 2; i < 6; i++) owner_pool[i] = OWNER_W'($urandom);

      while (pending_reqs.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            // Enough registrations to fill the whole table and run out.
            fill = $urandom_range(SLOTS + 1, SLOTS + 4);
            repeat (fill) queue_random(OP_REGISTER);
         end else if (roll < 20) queue_random(OP_REGISTER);
         else if (roll < 30) queue_random(OP_UNREGISTER);
         else if (roll < 55) queue_random(OP_FEED);
         else if (roll < 88) queue_random(OP_CHECK);
         else if (roll < 96) queue_random(OP_REMOVE_OWNER);
         else queue_random(OP_W'($urandom_range(int'(OP_REMOVE_OWNER) + 1, int'(OP_TOP))));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
